[src/selective_repeat_receiver_core_macros.svh]
// Assertion helpers for the receiver core; clk and rst_n come from the using module.
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRR_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SRR_ASSERT(label, prop, msg)
`define SRR_ASSERT_NEVER(label, cond, msg)
`endif

`endif

[src/srr_pkg.sv]
package srr_pkg;

    localparam int WINDOW_SIZE  = 8;
    localparam int SEQ_W        = 16;
    localparam int LEN_W        = 11;
    localparam int HANDLE_W     = 8;
    localparam int MAX_PAYLOAD  = 1024;
    localparam int HANDLE_COUNT = 256;
    localparam int SLOT_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLS_DISCARD,
        CLS_PREV,
        CLS_DELIVER,
        CLS_HOLD
    } class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_DISCARD,
        ST_DELIVER,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic                good;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
    } cmd_t;

endpackage

[src/selective_repeat_receiver_core.sv]
// Selective-repeat receiver core.
// Input queue side: a packet descriptor word (seq_number, checksum_ok,
// payload_length, buffer_handle) is taken on a clock edge with push high and
// full low. Result queue side: while empty is low the oldest result word
// (result_kind, seq_out, length_out, handle_out, last) is on the ports and is
// taken on an edge with pop high. Each descriptor yields one to nine words;
// last marks its final one.
// Path: a taken descriptor passes the front register, the two-word queue and
// the back command register; its first result word is then registered at
// the output. The back sequencer fetches a descriptor in its idle state, then
// emits its result words in turn and fetches no new one until the last word
// is emitted; a stalled result side holds it. The queue absorbs short bursts.
// cfg_we loads cfg_wdata into the window base and empties the reorder
// slots; write it only while idle. Reset sets the base to 0, clears all slot
// valid bits and empties both queues.
// A stalled result side holds the output word; the back stops, the command
// queue fills and then full rises.
module selective_repeat_receiver_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srr_pkg::SEQ_W-1:0]     cfg_wdata,
    input  logic                          push,
    output logic                          full,
    input  logic [srr_pkg::SEQ_W-1:0]     seq_number,
    input  logic                          checksum_ok,
    input  logic [srr_pkg::LEN_W-1:0]     payload_length,
    input  logic [srr_pkg::HANDLE_W-1:0]  buffer_handle,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    result_kind,
    output logic [srr_pkg::SEQ_W-1:0]     seq_out,
    output logic [srr_pkg::LEN_W-1:0]     length_out,
    output logic [srr_pkg::HANDLE_W-1:0]  handle_out,
    output logic                          last
);

    logic          f_valid;
    srr_pkg::cmd_t f_cmd;
    logic          q_full;
    logic          q_valid;
    srr_pkg::cmd_t q_cmd;
    logic          q_pop;

    srr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .seq_number     (seq_number),
        .checksum_ok    (checksum_ok),
        .payload_length (payload_length),
        .buffer_handle  (buffer_handle),
        .cmd_valid      (f_valid),
        .cmd            (f_cmd),
        .cmd_full       (q_full)
    );

    srr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_valid),
        .wr_cmd  (f_cmd),
        .q_full  (q_full),
        .q_valid (q_valid),
        .rd_cmd  (q_cmd),
        .rd_en   (q_pop)
    );

    srr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .result_kind (result_kind),
        .seq_out     (seq_out),
        .length_out  (length_out),
        .handle_out  (handle_out),
        .last        (last)
    );

endmodule

[src/srr_front.sv]
module srr_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [srr_pkg::SEQ_W-1:0]     seq_number,
    input  logic                          checksum_ok,
    input  logic [srr_pkg::LEN_W-1:0]     payload_length,
    input  logic [srr_pkg::HANDLE_W-1:0]  buffer_handle,
    output logic                          cmd_valid,
    output srr_pkg::cmd_t                 cmd,
    input  logic                          cmd_full
);

    logic          valid_reg;
    logic          valid_next;
    srr_pkg::cmd_t cmd_reg;
    logic          accept;
    logic          moved;
    logic          good;

    assign full   = valid_reg && cmd_full;
    assign accept = push && !full;
    assign moved  = valid_reg && !cmd_full;

    // corrupt: bad checksum, oversize payload or unknown buffer
    assign good = checksum_ok
               && (payload_length <= srr_pkg::LEN_W'(srr_pkg::MAX_PAYLOAD))
               && ({1'b0, buffer_handle} < (srr_pkg::HANDLE_W + 1)'(srr_pkg::HANDLE_COUNT));

    assign valid_next = accept || (valid_reg && !moved);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.seq    <= seq_number;
            cmd_reg.good   <= good;
            cmd_reg.len    <= payload_length;
            cmd_reg.handle <= buffer_handle;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

[src/srr_queue.sv]
module srr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  srr_pkg::cmd_t wr_cmd,
    output logic          q_full,
    output logic          q_valid,
    output srr_pkg::cmd_t rd_cmd,
    input  logic          rd_en
);

    srr_pkg::cmd_t mem [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && q_valid;
    assign rd_cmd  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

[src/srr_back.sv]
`include "selective_repeat_receiver_core_macros.svh"

module srr_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [srr_pkg::SEQ_W-1:0]     cfg_wdata,
    input  logic                          q_valid,
    input  srr_pkg::cmd_t                 q_cmd,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    result_kind,
    output logic [srr_pkg::SEQ_W-1:0]     seq_out,
    output logic [srr_pkg::LEN_W-1:0]     length_out,
    output logic [srr_pkg::HANDLE_W-1:0]  handle_out,
    output logic                          last
);

    localparam int W = srr_pkg::WINDOW_SIZE;
    localparam int SW = srr_pkg::SLOT_W;
    localparam logic [srr_pkg::SEQ_W-1:0] WIN_LIM  = srr_pkg::SEQ_W'(W);
    localparam logic [srr_pkg::SEQ_W-1:0] PREV_LOW =
        srr_pkg::SEQ_W'((64'd1 << srr_pkg::SEQ_W) - 64'(W));

    srr_pkg::state_t state_reg, state_next;
    srr_pkg::class_t cls_reg, cls_next;
    srr_pkg::cmd_t   cmd_reg;
    logic [SW-1:0]   slot_reg, slot_next;
    logic [srr_pkg::SEQ_W-1:0] base_reg;
    logic [SW-1:0]   head_reg;
    logic [SW-1:0]   head_inc;
    logic [W-1:0]    slot_valid_reg;
    logic [srr_pkg::LEN_W-1:0]    slot_len_mem    [W];
    logic [srr_pkg::HANDLE_W-1:0] slot_handle_mem [W];

    logic                          out_valid_reg;
    srr_pkg::kind_t                out_kind_reg;
    logic [srr_pkg::SEQ_W-1:0]     out_seq_reg;
    logic [srr_pkg::LEN_W-1:0]     out_len_reg;
    logic [srr_pkg::HANDLE_W-1:0]  out_handle_reg;
    logic                          out_last_reg;

    logic                          can_emit;
    logic                          emit;
    srr_pkg::kind_t                emit_kind;
    logic [srr_pkg::SEQ_W-1:0]     emit_seq;
    logic [srr_pkg::LEN_W-1:0]     emit_len;
    logic [srr_pkg::HANDLE_W-1:0]  emit_handle;
    logic                          emit_last;
    logic                          store_we;
    logic                          clear_we;
    logic                          advance;
    logic                          dup;
    logic                          more;

    logic [srr_pkg::SEQ_W-1:0]     offset;
    logic [SW:0]                   slot_sum;

    assign can_emit = !out_valid_reg || pop;
    assign head_inc = (head_reg == SW'(W - 1)) ? '0 : head_reg + SW'(1);
    assign dup      = slot_valid_reg[slot_reg];
    assign more     = slot_valid_reg[head_inc];

    // classify the queue head against the current window
    assign offset   = q_cmd.seq - base_reg;
    assign slot_sum = {1'b0, head_reg} + {1'b0, offset[SW-1:0]};

    always_comb
    begin
        if (!q_cmd.good)
        begin
            cls_next = srr_pkg::CLS_DISCARD;
        end
        else if (offset < WIN_LIM)
        begin
            cls_next = (offset == '0) ? srr_pkg::CLS_DELIVER : srr_pkg::CLS_HOLD;
        end
        else if (offset >= PREV_LOW)
        begin
            cls_next = srr_pkg::CLS_PREV;
        end
        else
        begin
            cls_next = srr_pkg::CLS_DISCARD;
        end
        slot_next = (slot_sum >= (SW + 1)'(W)) ? SW'(slot_sum - (SW + 1)'(W))
                                               : slot_sum[SW-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srr_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = srr_pkg::ST_FIRST;
                end
            end
            srr_pkg::ST_FIRST:
            begin
                if (can_emit)
                begin
                    unique case (cls_reg)
                        srr_pkg::CLS_DISCARD: state_next = srr_pkg::ST_IDLE;
                        srr_pkg::CLS_PREV:    state_next = srr_pkg::ST_DISCARD;
                        srr_pkg::CLS_DELIVER: state_next = srr_pkg::ST_DELIVER;
                        srr_pkg::CLS_HOLD:
                            state_next = dup ? srr_pkg::ST_DISCARD : srr_pkg::ST_IDLE;
                        default:              state_next = srr_pkg::ST_IDLE;
                    endcase
                end
            end
            srr_pkg::ST_DISCARD:
            begin
                if (can_emit)
                begin
                    state_next = srr_pkg::ST_IDLE;
                end
            end
            srr_pkg::ST_DELIVER, srr_pkg::ST_DRAIN:
            begin
                if (can_emit)
                begin
                    state_next = more ? srr_pkg::ST_DRAIN : srr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop       = 1'b0;
        emit        = 1'b0;
        emit_kind   = srr_pkg::KIND_ACK;
        emit_seq    = cmd_reg.seq;
        emit_len    = '0;
        emit_handle = '0;
        emit_last   = 1'b0;
        store_we    = 1'b0;
        clear_we    = 1'b0;
        advance     = 1'b0;
        unique case (state_reg)
            srr_pkg::ST_IDLE:
            begin
                q_pop = q_valid;
            end
            srr_pkg::ST_FIRST:
            begin
                emit = can_emit;
                if (cls_reg == srr_pkg::CLS_DISCARD)
                begin
                    emit_kind   = srr_pkg::KIND_DISCARD;
                    emit_len    = cmd_reg.len;
                    emit_handle = cmd_reg.handle;
                    emit_last   = 1'b1;
                end
                else
                begin
                    emit_last = (cls_reg == srr_pkg::CLS_HOLD) && !dup;
                    store_we  = can_emit && (cls_reg == srr_pkg::CLS_HOLD) && !dup;
                end
            end
            srr_pkg::ST_DISCARD:
            begin
                emit        = can_emit;
                emit_kind   = srr_pkg::KIND_DISCARD;
                emit_len    = cmd_reg.len;
                emit_handle = cmd_reg.handle;
                emit_last   = 1'b1;
            end
            srr_pkg::ST_DELIVER:
            begin
                emit        = can_emit;
                emit_kind   = srr_pkg::KIND_DELIVER;
                emit_len    = cmd_reg.len;
                emit_handle = cmd_reg.handle;
                emit_last   = !more;
                advance     = can_emit;
            end
            srr_pkg::ST_DRAIN:
            begin
                emit        = can_emit;
                emit_kind   = srr_pkg::KIND_DELIVER;
                emit_seq    = base_reg;
                emit_len    = slot_len_mem[head_reg];
                emit_handle = slot_handle_mem[head_reg];
                emit_last   = !more;
                clear_we    = can_emit;
                advance     = can_emit;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= srr_pkg::ST_IDLE;
            base_reg       <= '0;
            head_reg       <= '0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                base_reg       <= cfg_wdata;
                head_reg       <= '0;
                slot_valid_reg <= '0;
            end
            else
            begin
                if (advance)
                begin
                    base_reg <= base_reg + srr_pkg::SEQ_W'(1);
                    head_reg <= head_inc;
                end
                if (store_we)
                begin
                    slot_valid_reg[slot_reg] <= 1'b1;
                end
                if (clear_we)
                begin
                    slot_valid_reg[head_reg] <= 1'b0;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg  <= q_cmd;
            cls_reg  <= cls_next;
            slot_reg <= slot_next;
        end
        if (store_we)
        begin
            slot_len_mem[slot_reg]    <= cmd_reg.len;
            slot_handle_mem[slot_reg] <= cmd_reg.handle;
        end
        if (emit)
        begin
            out_kind_reg   <= emit_kind;
            out_seq_reg    <= emit_seq;
            out_len_reg    <= emit_len;
            out_handle_reg <= emit_handle;
            out_last_reg   <= emit_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign result_kind = out_kind_reg;
    assign seq_out     = out_seq_reg;
    assign length_out  = out_len_reg;
    assign handle_out  = out_handle_reg;
    assign last        = out_last_reg;

    `SRR_ASSERT(a_drain_slot_held, (state_reg == srr_pkg::ST_DRAIN) |-> slot_valid_reg[head_reg], "drain from empty slot")
    `SRR_ASSERT(a_last_ends_item, (emit && emit_last) |=> (state_reg == srr_pkg::ST_IDLE), "last word did not end the item")
    `SRR_ASSERT(a_hold_sets_slot, store_we |=> slot_valid_reg[$past(slot_reg)], "held packet not marked")
    `SRR_ASSERT_NEVER(a_pop_while_busy, q_pop && (state_reg != srr_pkg::ST_IDLE), "queue popped mid-item")

endmodule
